// File: hw/rtl/lz77_pkg.sv
// ============================================================================
// lz77_pkg
// Shared types and constants of the LZ77 token decoder.
// ============================================================================
package lz77_pkg;

    // history ring
    localparam int HIST_DEPTH = 4096;
    localparam int PTR_W      = $clog2(HIST_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    // window register
    localparam int WIN_W           = 4;
    localparam logic [WIN_W-1:0] WIN_BITS_RESET = 4'd12;
    localparam logic [WIN_W-1:0] WIN_BITS_MAX   = 4'd12;
    localparam logic [PTR_W-1:0] WIN_SMALL_SIZE = PTR_W'(HIST_DEPTH / 2);

    // token fields
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 5;
    localparam int OFF_W  = 12;
    localparam logic [LEN_W-1:0] LEN_MIN = 5'd2;
    localparam logic [LEN_W-1:0] LEN_MAX = 5'd16;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    // input command codes (carried on s_axis_tuser)
    localparam logic [1:0] CMD_LIT  = 2'd0;
    localparam logic [1:0] CMD_COPY = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;
    localparam logic [1:0] CMD_RSV  = 2'd3;

    // result status codes (carried on m_axis_tuser)
    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_LIT  = 2'd0,
        OP_COPY = 2'd1,
        OP_END  = 2'd2,
        OP_ERR  = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [BYTE_W-1:0] lit;
        logic [LEN_W-1:0]  len;
        logic [OFF_W-1:0]  off;
    } tok_t;

    // token queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: hw/rtl/lz77_queue.sv
// ============================================================================
// lz77_queue
// Short token queue between the classifying front and the executing back.
// ============================================================================
module lz77_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lz77_pkg::tok_t  din,
    input  logic            pop,
    output lz77_pkg::tok_t  dout,
    output lz77_pkg::q_stat_t stat
);
    import lz77_pkg::*;

    tok_t               entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout       = entry_reg[rd_ptr_reg];
    assign stat.full  = (fill_reg == (QPTR_W+1)'(QDEPTH));
    assign stat.empty = (fill_reg == '0);

endmodule

// File: hw/rtl/lz77_front.sv
// ============================================================================
// lz77_front
// Accepts tokens, checks copy offsets against the window and the number of
// bytes produced so far, and queues classified operations.
// ============================================================================
module lz77_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lz77_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]                       s_axis_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lz77_pkg::WIN_W-1:0]       cfg_data,
    input  lz77_pkg::q_stat_t                q_stat,
    output logic                             q_push,
    output lz77_pkg::tok_t                   q_din
);
    import lz77_pkg::*;

    logic [WIN_W-1:0]   win_bits_reg;
    logic [CNT_W-1:0]   prod_reg, prod_next;

    logic               accept;
    logic [BYTE_W-1:0]  lit;
    logic [LEN_W-1:0]   len_raw, len_sat;
    logic [OFF_W-1:0]   off;
    logic               bad_off;
    logic [CNT_W:0]     prod_sum;
    logic [LEN_W-1:0]   add_len;

    assign lit     = s_axis_tdata[BYTE_W-1:0];
    assign len_raw = s_axis_tdata[BYTE_W +: LEN_W];
    assign off     = s_axis_tdata[BYTE_W+LEN_W +: OFF_W];

    assign s_axis_tready = !q_stat.full;
    assign cfg_ready     = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        priority if (len_raw < LEN_MIN)
        begin
            len_sat = LEN_MIN;
        end
        else if (len_raw > LEN_MAX)
        begin
            len_sat = LEN_MAX;
        end
        else
        begin
            len_sat = len_raw;
        end

        // window clamps to 2048 below 12 bits, else the whole ring
        bad_off = (off == '0)
               || ({1'b0, off} > prod_reg)
               || ((win_bits_reg < WIN_BITS_MAX) && (off > WIN_SMALL_SIZE));

        q_din.lit = lit;
        q_din.len = len_sat;
        q_din.off = off;
        q_push    = accept && (s_axis_tuser != CMD_RSV);
        add_len   = '0;
        unique case (s_axis_tuser)
            CMD_LIT:
            begin
                q_din.op = OP_LIT;
                add_len  = LEN_W'(1);
            end
            CMD_COPY:
            begin
                q_din.op = bad_off ? OP_ERR : OP_COPY;
                add_len  = bad_off ? '0 : len_sat;
            end
            CMD_END:
            begin
                q_din.op = OP_END;
            end
            default:
            begin
                q_din.op = OP_END;
            end
        endcase

        prod_sum  = {1'b0, prod_reg} + (CNT_W+1)'(add_len);
        prod_next = prod_reg;
        if (q_push)
        begin
            prod_next = (prod_sum > (CNT_W+1)'(HIST_DEPTH)) ? CNT_W'(HIST_DEPTH)
                                                            : prod_sum[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_bits_reg <= WIN_BITS_RESET;
            prod_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                win_bits_reg <= cfg_data;
            end
            prod_reg <= prod_next;
        end
    end

endmodule

// File: hw/rtl/lz77_back.sv
// ============================================================================
// lz77_back
// Executes queued operations against the history ring and drives results
// through an output register.
// ============================================================================
module lz77_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lz77_pkg::q_stat_t                 q_stat,
    input  lz77_pkg::tok_t                    q_dout,
    output logic                              q_pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lz77_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);
    import lz77_pkg::*;

    logic [BYTE_W-1:0]  hist_mem [HIST_DEPTH];
    logic [BYTE_W-1:0]  rd_q_reg;

    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               byp_hit_reg, byp_hit_next;
    logic [BYTE_W-1:0]  byp_data_reg, byp_data_next;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    logic               out_free, emit, idle, pop_copy, pop_lit, issue, we, out_load;
    logic [BYTE_W-1:0]  b_val, wd;
    logic [PTR_W-1:0]   wp_after, rd_addr;
    logic [OFF_W-1:0]   off_sel;

    always_comb
    begin
        out_free = !out_valid_reg || m_axis_tready;
        b_val    = byp_hit_reg ? byp_data_reg : rd_q_reg;
        emit     = rd_pend_reg && out_free;
        idle     = (cnt_reg == '0);
        q_pop    = idle && !q_stat.empty && out_free;
        pop_copy = q_pop && (q_dout.op == OP_COPY);
        pop_lit  = q_pop && (q_dout.op == OP_LIT);
        issue    = pop_copy || (emit && (cnt_reg > LEN_W'(1)));

        we       = emit || pop_lit;
        wd       = emit ? b_val : q_dout.lit;
        wp_after = wp_reg + PTR_W'(we);
        wp_next  = wp_after;
        off_sel  = pop_copy ? q_dout.off : off_reg;
        rd_addr  = wp_after - PTR_W'(off_sel);

        off_next     = off_sel;
        rd_pend_next = issue ? 1'b1 : (emit ? 1'b0 : rd_pend_reg);
        // the byte being written now is what an offset-one read wants next
        byp_hit_next  = issue ? (emit && (rd_addr == wp_reg)) : byp_hit_reg;
        byp_data_next = issue ? b_val : byp_data_reg;

        cnt_next = cnt_reg;
        if (pop_copy)
        begin
            cnt_next = q_dout.len;
        end
        else if (emit)
        begin
            cnt_next = cnt_reg - 1'b1;
        end

        out_load        = emit || (q_pop && (q_dout.op != OP_COPY));
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            out_byte_next   = b_val;
            out_status_next = ST_DATA;
            out_last_next   = (cnt_reg == LEN_W'(1));
        end
        else if (out_load)
        begin
            out_last_next = 1'b1;
            unique case (q_dout.op)
                OP_LIT:
                begin
                    out_byte_next   = q_dout.lit;
                    out_status_next = ST_DATA;
                end
                OP_END:
                begin
                    out_byte_next   = '0;
                    out_status_next = ST_END;
                end
                OP_ERR:
                begin
                    out_byte_next   = '0;
                    out_status_next = ST_ERR;
                end
                default:
                begin
                    out_byte_next   = '0;
                    out_status_next = ST_ERR;
                end
            endcase
        end
        out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            hist_mem[wp_reg] <= wd;
        end
        if (issue)
        begin
            rd_q_reg <= hist_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            byp_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            byp_hit_reg   <= byp_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg        <= off_next;
        byp_data_reg   <= byp_data_next;
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: hw/rtl/lz77_token_decoder.sv
// ============================================================================
// lz77_token_decoder
// LZ77 token decoder with a 4096-byte history ring; split token fields in,
// one decoded byte or status marker out per result.
// ============================================================================
//
//  channel   dir   handshake              payload
//  s_axis    in    tvalid/tready          tuser=cmd, tdata=literal/length/offset
//  m_axis    out   tvalid/tready/tlast    tuser=status, tdata=data_byte
//  cfg       in    cfg_valid/cfg_ready    cfg_data=window_bits
//
//  Literal, end and error tokens load the output register when popped; a
//  copy first issues a registered history read, then yields one byte per
//  cycle while the output register is free to take it.
//  Reset clears pointers and counts; history contents stay undefined.
//  A two-entry token queue lets input and output stall independently.
//
module lz77_token_decoder
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] literal_byte, [12:8] copy_length, [24:13] copy_offset, [31:25] zero
    input  logic [lz77_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] data_byte
    output logic [lz77_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lz77_pkg::WIN_W-1:0]       cfg_data
);
    import lz77_pkg::*;

    logic    q_push, q_pop;
    tok_t    q_din, q_dout;
    q_stat_t q_stat;

    lz77_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_din         (q_din)
    );

    lz77_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .stat  (q_stat)
    );

    lz77_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_dout        (q_dout),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef ASSERT_OFF
    // end and error markers are single zero-byte results
    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_DATA) |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("marker result without tlast or with nonzero data");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !q_push)
        else $error("token pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !q_pop)
        else $error("token popped from empty queue");
`endif

endmodule
